[hw/rtl/dc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dc_pkg;

   localparam int IDX_W      = 6;
   localparam int X_W        = 32;
   localparam int N_W        = 7;
   localparam int NN_W       = 2 * N_W;
   localparam int DEN_W      = NN_W + 1;
   localparam int RS_W       = 40;
   localparam int GT_W       = 48;
   localparam int NUM_W      = 50;
   localparam int Y_W        = 34;
   localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;

   localparam int DEF_MAX_SIZE = 64;

   localparam logic [N_W-1:0] SIZE_RESET = N_W'(64);

   localparam logic FUNC_ACC  = 1'b0;
   localparam logic FUNC_EMIT = 1'b1;

   localparam logic CSR_IDX_SIZE = 1'b0;

   localparam logic [NUM_W-1:0] Y_POS_LIM = {{(NUM_W-Y_W+1){1'b0}}, {(Y_W-1){1'b1}}};
   localparam logic [NUM_W-1:0] Y_NEG_LIM = Y_POS_LIM + NUM_W'(1);

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

[hw/rtl/dc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module dc_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

[hw/rtl/dc_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
module dc_divider
   import dc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic      [NUM_W-1:0] quotient,
   output div_status_type        status
);

   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   div_status_type       stat_ff, stat_in;

   logic [DEN_W:0] shifted;
   logic [DEN_W:0] diff;
   logic           ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});

      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      cnt_in       = cnt_ff;
      stat_in.busy = stat_ff.busy;
      stat_in.done = 1'b0;

      if (start) begin
         quo_in       = dividend;
         rem_in       = '0;
         den_in       = divisor;
         cnt_in       = DIV_CNT_W'(NUM_W);
         stat_in.busy = 1'b1;
      end else if (stat_ff.busy) begin
         quo_in = {quo_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            stat_in.busy = 1'b0;
            stat_in.done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         stat_ff <= stat_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign status   = stat_ff;

endmodule

`default_nettype wire

[hw/rtl/double_centering.sv]
`timescale 1ns / 1ps
`default_nettype none

// Double centering of a symmetric Q16.16 matrix sent twice as its lower
// triangle: an accumulate pass (tuser[0] = 0) builds row sums and the grand
// total, an emit pass (tuser[0] = 1) returns one centered element per
// transfer. tuser[1] on an accumulate transfer clears all sums first. The
// block takes one item at a time. An accumulate item reads the row sum,
// writes it back with the element added and, off the diagonal, does the
// same for the column sum (read then write per index); an item whose row is
// not below n goes straight back to idle. An emit item runs six multiply
// and add steps on one shared multiplier, then a 50-step restoring divider
// that yields one quotient bit per cycle. The matrix order n is written at
// csr address 0 and is clamped to 1..MAX_SIZE. Sums are cleared at once by
// per-row valid bits, so no clearing pass follows reset.
module double_centering
   import dc_pkg::*;
#(
   parameter int MAX_SIZE = DEF_MAX_SIZE
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [5:0] row_index, [11:6] col_index, [43:12] element_value, [47:44] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] func, [1] first
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [5:0] out_row, [11:6] out_col, [45:12] centered_value, [47:46] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int AW    = $clog2(MAX_SIZE);
   localparam int CMP_W = ($clog2(MAX_SIZE + 1) > N_W) ? $clog2(MAX_SIZE + 1) : N_W;
   localparam int PROD_W = RS_W + NN_W + 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_RD,
      S_A_WR_R,
      S_A_WR_C,
      S_E_NN,
      S_E_X,
      S_E_R,
      S_E_C,
      S_E_T,
      S_E_G,
      S_E_DIV,
      S_E_WAIT,
      S_E_OUT
   } state_type;

   function automatic logic in_range(input logic [IDX_W-1:0] idx);
      in_range = (CMP_W'(idx) < CMP_W'(MAX_SIZE));
   endfunction

   state_type               state_ff, state_in;
   logic [N_W-1:0]          size_ff, size_in;
   logic [IDX_W-1:0]        row_ff, row_in;
   logic [IDX_W-1:0]        col_ff, col_in;
   logic signed [X_W-1:0]   x_ff, x_in;
   logic [NN_W-1:0]         nn_ff, nn_in;
   logic signed [RS_W-1:0]  rsa_ff, rsa_in;
   logic signed [RS_W-1:0]  rsb_ff, rsb_in;
   logic signed [NUM_W-1:0] prod_ff, prod_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic signed [GT_W-1:0]  gt_ff, gt_in;
   logic [MAX_SIZE-1:0]     vld_ff, vld_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        rsp_row_ff, rsp_row_in;
   logic [IDX_W-1:0]        rsp_col_ff, rsp_col_in;
   logic [Y_W-1:0]          rsp_val_ff, rsp_val_in;

   logic [N_W-1:0]          n_eff;
   logic [IDX_W-1:0]        in_row, in_col, sw_row, sw_col;
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr, ram_raddr;
   logic [IDX_W-1:0]        wr_idx, rd_idx, mask_idx;
   logic [RS_W-1:0]         ram_wdata, ram_rdata;
   logic signed [RS_W-1:0]  rs_rd;
   logic signed [RS_W-1:0]  mul_a;
   logic [NN_W-1:0]         mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic                    div_start;
   logic [NUM_W-1:0]        div_dividend;
   logic [NUM_W-1:0]        div_quotient;
   div_status_type          div_stat;
   logic [Y_W-1:0]          y_sat;
   logic                    csr_wr;

   always_comb begin
      if (size_ff == '0) begin
         n_eff = N_W'(1);
      end else if (CMP_W'(size_ff) > CMP_W'(MAX_SIZE)) begin
         n_eff = N_W'(MAX_SIZE);
      end else begin
         n_eff = size_ff;
      end
   end

   assign in_row = req_tdata[IDX_W-1:0];
   assign in_col = req_tdata[2*IDX_W-1:IDX_W];
   assign sw_row = (in_row < in_col) ? in_col : in_row;
   assign sw_col = (in_row < in_col) ? in_row : in_col;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_SIZE)
                       ? CSR_DATA_W'(size_ff) : '0;

   // row sum memory
   assign ram_we    = (state_ff == S_A_WR_R) || (state_ff == S_A_WR_C);
   assign wr_idx    = (state_ff == S_A_WR_R) ? row_ff : col_ff;
   assign rd_idx    = ((state_ff == S_A_WR_R) || (state_ff == S_E_X)) ? col_ff : row_ff;
   assign mask_idx  = ((state_ff == S_A_WR_R) || (state_ff == S_E_X)) ? row_ff : col_ff;
   assign ram_waddr = AW'(wr_idx);
   assign ram_raddr = AW'(rd_idx);
   assign rs_rd     = (in_range(mask_idx) && vld_ff[AW'(mask_idx)]) ? ram_rdata : '0;
   assign ram_wdata = rs_rd + RS_W'(x_ff);

   dc_ram #(
      .WIDTH (RS_W),
      .DEPTH (MAX_SIZE)
   ) u_rs_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_E_NN: begin
            mul_a = RS_W'(n_eff);
            mul_b = NN_W'(n_eff);
         end
         S_E_X: begin
            mul_a = RS_W'(x_ff);
            mul_b = prod_ff[NN_W-1:0];
         end
         S_E_R: begin
            mul_a = rsa_ff;
            mul_b = NN_W'(n_eff);
         end
         S_E_C: begin
            mul_a = rsb_ff;
            mul_b = NN_W'(n_eff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * $signed({1'b0, mul_b});
   end

   assign div_dividend = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);

   dc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  ({nn_ff, 1'b0}),
      .quotient (div_quotient),
      .status   (div_stat)
   );

   always_comb begin
      if (neg_ff) begin
         y_sat = (div_quotient > Y_NEG_LIM) ? Y_NEG_LIM[Y_W-1:0]
                                            : (~div_quotient[Y_W-1:0] + Y_W'(1));
      end else begin
         y_sat = (div_quotient > Y_POS_LIM) ? Y_POS_LIM[Y_W-1:0]
                                            : div_quotient[Y_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      x_in         = x_ff;
      nn_in        = nn_ff;
      rsa_in       = rsa_ff;
      rsb_in       = rsb_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      gt_in        = gt_ff;
      vld_in       = vld_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_val_in   = rsp_val_ff;
      div_start    = 1'b0;

      if (csr_wr && (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_SIZE)) begin
         size_in = csr_pwdata[N_W-1:0];
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               row_in = sw_row;
               col_in = sw_col;
               x_in   = req_tdata[2*IDX_W+X_W-1:2*IDX_W];
               if (req_tuser[0] == FUNC_EMIT) begin
                  state_in = S_E_NN;
               end else begin
                  if (req_tuser[1]) begin
                     vld_in = '0;
                     gt_in  = '0;
                  end
                  if ({1'b0, sw_row} >= n_eff) begin
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_A_RD;
                  end
               end
            end
         end
         S_A_RD: begin
            state_in = S_A_WR_R;
         end
         S_A_WR_R: begin
            vld_in[ram_waddr] = 1'b1;
            gt_in = gt_ff + GT_W'(x_ff);
            state_in = (row_ff == col_ff) ? S_IDLE : S_A_WR_C;
         end
         S_A_WR_C: begin
            vld_in[ram_waddr] = 1'b1;
            gt_in = gt_ff + GT_W'(x_ff);
            state_in = S_IDLE;
         end
         S_E_NN: begin
            prod_in  = mul_p[NUM_W-1:0];
            state_in = S_E_X;
         end
         S_E_X: begin
            nn_in    = prod_ff[NN_W-1:0];
            rsa_in   = rs_rd;
            prod_in  = mul_p[NUM_W-1:0];
            state_in = S_E_R;
         end
         S_E_R: begin
            rsb_in   = rs_rd;
            num_in   = prod_ff;
            prod_in  = mul_p[NUM_W-1:0];
            state_in = S_E_C;
         end
         S_E_C: begin
            num_in   = num_ff - prod_ff;
            prod_in  = mul_p[NUM_W-1:0];
            state_in = S_E_T;
         end
         S_E_T: begin
            num_in   = num_ff - prod_ff;
            state_in = S_E_G;
         end
         S_E_G: begin
            num_in   = num_ff + NUM_W'(gt_ff);
            state_in = S_E_DIV;
         end
         S_E_DIV: begin
            div_start = 1'b1;
            neg_in    = (num_ff > 0);
            state_in  = S_E_WAIT;
         end
         S_E_WAIT: begin
            if (div_stat.done) begin
               state_in = S_E_OUT;
            end
         end
         S_E_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_col_in   = col_ff;
               rsp_val_in   = y_sat;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= SIZE_RESET;
         gt_ff        <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         gt_ff        <= gt_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff     <= row_in;
      col_ff     <= col_in;
      x_ff       <= x_in;
      nn_ff      <= nn_in;
      rsa_ff     <= rsa_in;
      rsb_ff     <= rsb_in;
      prod_ff    <= prod_in;
      num_ff     <= num_in;
      neg_ff     <= neg_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_val_ff <= rsp_val_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2*IDX_W-Y_W){1'b0}}, rsp_val_ff, rsp_col_ff, rsp_row_ff};

   a_wr_in_size: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ({1'b0, wr_idx} < n_eff))
      else $error("row sum write outside matrix order");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_E_WAIT))
      else $error("divider result not awaited");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_E_OUT))
      else $error("result raised outside output step");

endmodule

`default_nettype wire
